@@ src/kdps_pkg.sv @@
// ----------------------------------------------------------------------------
// kdps_pkg
// Shared widths, register indexes and reset values for the key debounce and
// press-event block.
// ----------------------------------------------------------------------------
package kdps_pkg;

  // Default sizing of the key array and the per-key tick timers.
  localparam int NUM_KEYS_DEF   = 4;
  localparam int TIMER_BITS_DEF = 16;

  // Beat field widths.
  localparam int LEVELS_W  = 4;
  localparam int CLEAR_W   = 2;
  localparam int STATES_W  = 12;
  localparam int FLAGS_W   = 4;
  localparam int MODE_W    = 3;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W      = 8;
  localparam int TICKS_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ENABLE = 3'd4;

  // Register reset values.
  localparam logic [DEB_W-1:0]   DEBOUNCE_RST      = 8'd3;
  localparam logic [TICKS_W-1:0] REPEAT_RST        = 16'd100;
  localparam logic [TICKS_W-1:0] DOUBLE_WINDOW_RST = 16'd30;
  localparam logic [TICKS_W-1:0] DOUBLE_GAP_RST    = 16'd50;
  localparam logic               DOUBLE_ENABLE_RST = 1'b1;

  // Hold counter saturates here.
  localparam logic [7:0] HOLD_MAX = 8'd255;

endpackage

@@ src/key_debounce_press_state_machine_unit.sv @@
// ----------------------------------------------------------------------------
// key_debounce_press_state_machine_unit
// Debounce and click / double-click / long-press event tracking for a row of
// active-low keys, advanced one scan tick per scan beat.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | slave     | in_tvalid / in_tready  | tuser: kind; tdata: levels, key
//  out_    | master    | out_tvalid / out_tready| tdata: key states, new flags
//  cfg_    | slave     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Each beat passes through the input register and then the result register.
//  A new beat is accepted every cycle unless out_tready stalls the pipeline.
//  Key state is updated when a beat moves from the input register into the
//  result register, so updates happen strictly in beat order.
//  A stall on out_tready holds both registers; in_tready drops only when the
//  input register is full and cannot move on. cfg_ready is always high.
//  Reset (rst_n low, synchronous) empties both registers, clears all per-key
//  state and loads the register defaults.
// ----------------------------------------------------------------------------
module key_debounce_press_state_machine_unit #(
  parameter int NUM_KEYS   = kdps_pkg::NUM_KEYS_DEF,
  parameter int TIMER_BITS = kdps_pkg::TIMER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input beats.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kdps_pkg::IN_DATA_W-1:0]   in_tdata,   // [3:0] key_levels, [5:4] clear_key
  input  logic                             in_tuser,   // [0] kind
  // Result beats.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kdps_pkg::OUT_DATA_W-1:0]  out_tdata,  // [11:0] key_states, [15:12] new_flags
  // Configuration writes.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kdps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (TIMER_BITS > kdps_pkg::TICKS_W) ? TIMER_BITS : kdps_pkg::TICKS_W;
  localparam int OUT_KEYS = kdps_pkg::FLAGS_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [kdps_pkg::MODE_W-1:0] {
    MODE_NONE      = 3'd0,
    MODE_DOWN      = 3'd1,
    MODE_WAIT      = 3'd2,
    MODE_UP        = 3'd3,
    MODE_REPEAT    = 3'd4,
    MODE_DOUBLE    = 3'd5,
    MODE_DOUBLE_UP = 3'd6
  } mode_t;

  // Configuration registers.
  logic [kdps_pkg::DEB_W-1:0]   deb_r;
  logic [kdps_pkg::TICKS_W-1:0] rep_r;
  logic [kdps_pkg::TICKS_W-1:0] win_r;
  logic [kdps_pkg::TICKS_W-1:0] gap_r;
  logic                         den_r;

  // Input register.
  logic                          s1_v_r;
  logic                          kind_r;
  logic [kdps_pkg::LEVELS_W-1:0] lvl_r;
  logic [kdps_pkg::CLEAR_W-1:0]  clr_r;

  // Result register.
  logic                            out_v_r;
  logic [kdps_pkg::OUT_DATA_W-1:0] out_data_r;

  // Per-key state.
  mode_t                 mode_r    [NUM_KEYS];
  mode_t                 mode_nxt  [NUM_KEYS];
  logic [7:0]            hold_r    [NUM_KEYS];
  logic [7:0]            hold_nxt  [NUM_KEYS];
  logic [TIMER_BITS-1:0] ptim_r    [NUM_KEYS];
  logic [TIMER_BITS-1:0] ptim_nxt  [NUM_KEYS];
  logic [TIMER_BITS-1:0] gtim_r    [NUM_KEYS];
  logic [TIMER_BITS-1:0] gtim_nxt  [NUM_KEYS];
  logic [NUM_KEYS-1:0]   flag_r;
  logic [NUM_KEYS-1:0]   flag_nxt;
  logic [NUM_KEYS-1:0]   lock_r;
  logic [NUM_KEYS-1:0]   lock_nxt;

  logic                          adv;
  logic                          proc;
  logic [NUM_KEYS-1:0]           key_lvl;
  logic [kdps_pkg::STATES_W-1:0] states_pack;
  logic [kdps_pkg::FLAGS_W-1:0]  flags_pack;

  // The pipeline moves whenever the result register is free or being taken.
  assign adv       = !out_v_r || out_tready;
  assign proc      = s1_v_r && adv;
  assign in_tready = !s1_v_r || adv;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // Pin levels of keys beyond the level field read as pressed.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
    if (k < kdps_pkg::LEVELS_W) begin : g_pin
      assign key_lvl[k] = lvl_r[k];
    end else begin : g_pad
      assign key_lvl[k] = 1'b0;
    end
  end

  // Pack the updated states and flags of the visible keys.
  for (genvar j = 0; j < OUT_KEYS; j++) begin : g_pack
    if (j < NUM_KEYS) begin : g_key
      assign states_pack[kdps_pkg::MODE_W*j +: kdps_pkg::MODE_W] = mode_nxt[j];
      assign flags_pack[j] = flag_nxt[j];
    end else begin : g_none
      assign states_pack[kdps_pkg::MODE_W*j +: kdps_pkg::MODE_W] = '0;
      assign flags_pack[j] = 1'b0;
    end
  end

  // Next state of every key; all keys update side by side.
  always_comb begin
    logic [TIMER_BITS-1:0] pt;
    logic [TIMER_BITS-1:0] gt;
    logic [7:0]            hc;
    logic                  pressed;
    logic                  released;
    mode_t                 md;
    logic                  fl;
    logic                  lk;
    for (int k = 0; k < NUM_KEYS; k++) begin
      pt       = (ptim_r[k] != TIMER_MAX) ? ptim_r[k] + TIMER_BITS'(1) : ptim_r[k];
      gt       = (gtim_r[k] != TIMER_MAX) ? gtim_r[k] + TIMER_BITS'(1) : gtim_r[k];
      hc       = key_lvl[k] ? 8'd0 :
                 ((hold_r[k] != kdps_pkg::HOLD_MAX) ? hold_r[k] + 8'd1 : hold_r[k]);
      pressed  = hc >= deb_r;
      released = hc == 8'd0;
      md       = mode_r[k];
      fl       = flag_r[k];
      lk       = lock_r[k];

      if (den_r) begin
        case (mode_r[k])
          MODE_NONE: begin
            if (pressed) begin
              md = MODE_DOWN;
              pt = '0;
            end
          end
          MODE_DOWN: begin
            if (released) begin
              md = MODE_WAIT;
              pt = '0;
            end
            // A long hold wins over a release seen in the same tick.
            if (CMP_W'(pt) >= CMP_W'(rep_r)) begin
              md = MODE_REPEAT;
              fl = 1'b1;
            end
          end
          MODE_WAIT: begin
            if (CMP_W'(pt) >= CMP_W'(win_r)) begin
              md = MODE_UP;
              fl = 1'b1;
            end
            // A second press while unlocked wins over the window timeout.
            if (!lock_r[k] && pressed) begin
              md = MODE_DOUBLE;
            end
          end
          MODE_UP: begin
            if (!flag_r[k]) begin
              md = MODE_NONE;
            end
          end
          MODE_REPEAT: begin
            if (released) begin
              md = MODE_NONE;
            end
          end
          MODE_DOUBLE: begin
            if (released) begin
              md = MODE_DOUBLE_UP;
              fl = 1'b1;
            end
          end
          MODE_DOUBLE_UP: begin
            if (!flag_r[k]) begin
              md = MODE_NONE;
              lk = 1'b1;
              gt = '0;
            end
          end
          default: begin
          end
        endcase
        // The lockout ends once the gap has run out.
        if (lk && (CMP_W'(gt) >= CMP_W'(gap_r))) begin
          lk = 1'b0;
        end
      end else begin
        case (mode_r[k])
          MODE_NONE: begin
            if (pressed) begin
              md = MODE_DOWN;
              pt = '0;
            end
          end
          MODE_DOWN: begin
            if (released) begin
              md = MODE_UP;
              fl = 1'b1;
            end
            if (CMP_W'(pt) >= CMP_W'(rep_r)) begin
              md = MODE_REPEAT;
              fl = 1'b1;
            end
          end
          MODE_UP: begin
            if (!flag_r[k]) begin
              md = MODE_NONE;
            end
          end
          MODE_REPEAT: begin
            if (released) begin
              md = MODE_NONE;
            end
          end
          default: begin
          end
        endcase
      end

      // Scan beats advance everything; a clear beat only drops one flag.
      if (proc && !kind_r) begin
        mode_nxt[k] = md;
        hold_nxt[k] = hc;
        ptim_nxt[k] = pt;
        gtim_nxt[k] = gt;
        flag_nxt[k] = fl;
        lock_nxt[k] = lk;
      end else begin
        mode_nxt[k] = mode_r[k];
        hold_nxt[k] = hold_r[k];
        ptim_nxt[k] = ptim_r[k];
        gtim_nxt[k] = gtim_r[k];
        flag_nxt[k] = (proc && kind_r && (32'(clr_r) == k)) ? 1'b0 : flag_r[k];
        lock_nxt[k] = lock_r[k];
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= kdps_pkg::DEBOUNCE_RST;
      rep_r <= kdps_pkg::REPEAT_RST;
      win_r <= kdps_pkg::DOUBLE_WINDOW_RST;
      gap_r <= kdps_pkg::DOUBLE_GAP_RST;
      den_r <= kdps_pkg::DOUBLE_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kdps_pkg::REG_DEBOUNCE:      deb_r <= cfg_data[kdps_pkg::DEB_W-1:0];
        kdps_pkg::REG_REPEAT:        rep_r <= cfg_data;
        kdps_pkg::REG_DOUBLE_WINDOW: win_r <= cfg_data;
        kdps_pkg::REG_DOUBLE_GAP:    gap_r <= cfg_data;
        kdps_pkg::REG_DOUBLE_ENABLE: den_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser;
      lvl_r  <= in_tdata[kdps_pkg::LEVELS_W-1:0];
      clr_r  <= in_tdata[kdps_pkg::LEVELS_W +: kdps_pkg::CLEAR_W];
    end
    if (proc) begin
      out_data_r <= {flags_pack, states_pack};
    end
  end

  // Per-key state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        mode_r[k] <= MODE_NONE;
        hold_r[k] <= '0;
        ptim_r[k] <= '0;
        gtim_r[k] <= '0;
      end
      flag_r <= '0;
      lock_r <= '0;
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        mode_r[k] <= mode_nxt[k];
        hold_r[k] <= hold_nxt[k];
        ptim_r[k] <= ptim_nxt[k];
        gtim_r[k] <= gtim_nxt[k];
      end
      flag_r <= flag_nxt;
      lock_r <= lock_nxt;
    end
  end

  // A beat leaving the input register always lands in the result register.
  a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> out_tvalid)
    else $error("beat left the input register without a result");

  // A clear beat for key 0 leaves its flag low.
  a_clear_key0: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && kind_r && (clr_r == '0)) |=> !flag_r[0])
    else $error("clear beat did not drop the flag of key 0");

  // The double-press lockout of key 0 is only armed on leaving double up.
  a_lock_arm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(lock_r[0]) |-> $past(mode_r[0] == MODE_DOUBLE_UP))
    else $error("lockout armed outside double up");

endmodule
